/* rtl/wpf_pkg.sv */
package wpf_pkg;

  localparam int MAX_POOL_DEF    = 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int OUT_POS_W  = 10;
  localparam int CMP_W      = 16;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  typedef enum logic [1:0] {
    MODE_MAX     = 2'd0,
    MODE_MIN     = 2'd1,
    MODE_AVERAGE = 2'd2,
    MODE_AVG_ALT = 2'd3
  } pool_mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_PW     = 3'd1,
    REG_PH     = 3'd2,
    REG_STRIDE = 3'd3,
    REG_IW     = 3'd4,
    REG_IH     = 3'd5,
    REG_NONE6  = 3'd6,
    REG_NONE7  = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_LACC = 6'b000100,
    ST_SHFT = 6'b001000,
    ST_RED  = 6'b010000,
    ST_DIV  = 6'b100000
  } state_t;

endpackage

/* rtl/window_pooling_forward.sv */
// Channel  | Handshake              | Payload
// in       | in_valid / in_ready    | in_sample
// out      | out_valid / out_ready  | out_pooled_value, out_row, out_col, out_frame_done
// cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
// One item at a time: accept, pool_height-1 line store reads (one read port),
// then one shift of the column cell chain.
// An item that closes a window then passes the reduce state, and in average mode
// the divider as well. A result waits until the output register is free; while
// it waits, the input is held.
// Reset is synchronous; line store and cells hold no reset and need no clearing.
module window_pooling_forward
  import wpf_pkg::*;
#(
  parameter int MAX_POOL    = MAX_POOL_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_pooled_value,
  output logic [OUT_POS_W-1:0]          out_row,
  output logic [OUT_POS_W-1:0]          out_col,
  output logic                          out_frame_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int LG     = $clog2(MAX_POOL);
  localparam int CSW    = SB + LG;
  localparam int TSW    = SB + 2 * LG + 1;
  localparam int DVW    = 2 * LG + 1;
  localparam int PW_W   = $clog2(MAX_POOL + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WC_W   = $clog2(MAX_WIDTH + 1);
  localparam int RING   = (MAX_POOL > 1) ? (MAX_POOL - 1) : 1;
  localparam int SLOT_W = (RING > 1) ? $clog2(RING) : 1;
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration
  logic [1:0]  mode_r;
  logic [3:0]  pw_reg_r, ph_reg_r, st_reg_r;
  logic [10:0] iw_reg_r, ih_reg_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MODE:   prdata = APB_DW'(mode_r);
      REG_PW:     prdata = APB_DW'(pw_reg_r);
      REG_PH:     prdata = APB_DW'(ph_reg_r);
      REG_STRIDE: prdata = APB_DW'(st_reg_r);
      REG_IW:     prdata = APB_DW'(iw_reg_r);
      REG_IH:     prdata = APB_DW'(ih_reg_r);
      default:    prdata = '0;
    endcase
  end

  logic cfg_hit;
  assign cfg_hit = cfg_wr && (cfg_idx != REG_NONE6) && (cfg_idx != REG_NONE7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MAX;
      pw_reg_r <= 4'd2;
      ph_reg_r <= 4'd2;
      st_reg_r <= 4'd2;
      iw_reg_r <= 11'd1024;
      ih_reg_r <= 11'd1024;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_r   <= pwdata[1:0];
        REG_PW:     pw_reg_r <= pwdata[3:0];
        REG_PH:     ph_reg_r <= pwdata[3:0];
        REG_STRIDE: st_reg_r <= pwdata[3:0];
        REG_IW:     iw_reg_r <= pwdata[10:0];
        REG_IH:     ih_reg_r <= pwdata[10:0];
        default:    ;
      endcase
    end
  end

  // clamped settings
  logic [PW_W-1:0] pw_c, ph_c;
  logic [3:0]      st_c;
  logic [WC_W-1:0] w_c;
  logic [10:0]     h_c;
  logic            avg_mode;

  always_comb begin
    pw_c = (pw_reg_r == 4'd0) ? PW_W'(1) :
           (CMP_W'(pw_reg_r) > CMP_W'(MAX_POOL)) ? PW_W'(MAX_POOL) : PW_W'(pw_reg_r);
    ph_c = (ph_reg_r == 4'd0) ? PW_W'(1) :
           (CMP_W'(ph_reg_r) > CMP_W'(MAX_POOL)) ? PW_W'(MAX_POOL) : PW_W'(ph_reg_r);
    st_c = (st_reg_r == 4'd0) ? 4'd1 : st_reg_r;
    w_c  = (iw_reg_r == 11'd0) ? WC_W'(1) :
           (CMP_W'(iw_reg_r) > CMP_W'(MAX_WIDTH)) ? WC_W'(MAX_WIDTH) : WC_W'(iw_reg_r);
    h_c  = (ih_reg_r == 11'd0) ? 11'd1 :
           (ih_reg_r > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : ih_reg_r;
  end

  assign avg_mode = mode_r[1];

  // positions and stride phases
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [SLOT_W-1:0]    wr_slot_r, rd_slot_r;
  logic [3:0]           cph_r, rph_r;
  logic [OUT_POS_W-1:0] ox_r, oy_r;

  logic [CMP_W-1:0]     c1, r1;
  logic                 col_start, row_start, col_el, row_el, elig, last;
  logic [3:0]           cph_e, rph_e;
  logic [OUT_POS_W-1:0] ox_e, oy_e;

  assign c1        = CMP_W'(col_r) + CMP_W'(1);
  assign r1        = CMP_W'(row_r) + CMP_W'(1);
  assign col_start = (c1 == CMP_W'(pw_c));
  assign row_start = (r1 == CMP_W'(ph_c));
  assign col_el    = (c1 >= CMP_W'(pw_c));
  assign row_el    = (r1 >= CMP_W'(ph_c));
  assign cph_e     = col_start ? 4'd0 : cph_r;
  assign rph_e     = row_start ? 4'd0 : rph_r;
  assign ox_e      = col_start ? '0 : ox_r;
  assign oy_e      = row_start ? '0 : oy_r;
  assign elig      = col_el && row_el && (cph_e == 4'd0) && (rph_e == 4'd0);
  assign last      = (CMP_W'(row_r) + CMP_W'(st_c) >= CMP_W'(h_c)) &&
                     (CMP_W'(col_r) + CMP_W'(st_c) >= CMP_W'(w_c));

  // control
  state_t state_r, state_nxt;
  logic   accept, shift_en, mem_re, div_start, div_done, emit;

  logic             res_pend_r;
  logic [PW_W-1:0]  y_r;

  // hold IDLE until the previous result has gone
  logic go_idle_blocked;
  assign go_idle_blocked = res_pend_r && !emit;

  assign in_ready  = (state_r == ST_IDLE) && !go_idle_blocked;
  assign accept    = in_valid && in_ready;
  assign shift_en  = (state_r == ST_SHFT);
  assign mem_re    = (state_r == ST_LOAD);
  assign div_start = (state_r == ST_RED) && avg_mode;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = (ph_c > PW_W'(1)) ? ST_LOAD : ST_SHFT;
      ST_LOAD: state_nxt = ST_LACC;
      ST_LACC: state_nxt = ((y_r + PW_W'(1)) < ph_c) ? ST_LOAD : ST_SHFT;
      ST_SHFT: state_nxt = elig ? ST_RED : ST_IDLE;
      ST_RED:  state_nxt = avg_mode ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else if (!(state_r == ST_IDLE && go_idle_blocked)) state_r <= state_nxt;
  end

  // line store
  logic [SB-1:0]     mem [DEPTH];
  logic [SB-1:0]     mem_q_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic signed [SB-1:0] s_r;

  assign rd_addr = ADDR_W'(rd_slot_r * MAX_WIDTH) + ADDR_W'(col_r);
  assign wr_addr = ADDR_W'(wr_slot_r * MAX_WIDTH) + ADDR_W'(col_r);

  always_ff @(posedge clk) begin
    if (shift_en) mem[wr_addr] <= s_r;
    if (mem_re) mem_q_r <= mem[rd_addr];
  end

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_W'(RING - 1) : s - SLOT_W'(1);
  endfunction

  // newest column aggregate
  logic signed [SB-1:0]  nc_max_r, nc_min_r;
  logic signed [CSW-1:0] nc_sum_r;
  logic signed [SB-1:0]  mq;

  assign mq = mem_q_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s_r       <= in_sample;
      nc_max_r  <= in_sample;
      nc_min_r  <= in_sample;
      nc_sum_r  <= CSW'(in_sample);
      y_r       <= PW_W'(1);
      rd_slot_r <= slot_dec(wr_slot_r);
    end else if (state_r == ST_LACC) begin
      if (mq > nc_max_r) nc_max_r <= mq;
      if (mq < nc_min_r) nc_min_r <= mq;
      nc_sum_r  <= nc_sum_r + CSW'(mq);
      y_r       <= y_r + PW_W'(1);
      rd_slot_r <= slot_dec(rd_slot_r);
    end
  end

  // position update
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r     <= '0;
      row_r     <= '0;
      wr_slot_r <= '0;
    end else if (shift_en) begin
      if (c1 >= CMP_W'(w_c)) begin
        col_r <= '0;
        if (r1 >= CMP_W'(h_c)) begin
          row_r     <= '0;
          wr_slot_r <= '0;
        end else begin
          row_r     <= row_r + ROW_W'(1);
          wr_slot_r <= (wr_slot_r == SLOT_W'(RING - 1)) ? '0 : wr_slot_r + SLOT_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      if (cph_e + 4'd1 == st_c) begin
        cph_r <= 4'd0;
        ox_r  <= ox_e + OUT_POS_W'(1);
      end else begin
        cph_r <= cph_e + 4'd1;
        ox_r  <= ox_e;
      end
      if (c1 >= CMP_W'(w_c)) begin
        if (rph_e + 4'd1 == st_c) begin
          rph_r <= 4'd0;
          oy_r  <= oy_e + OUT_POS_W'(1);
        end else begin
          rph_r <= rph_e + 4'd1;
          oy_r  <= oy_e;
        end
      end
    end
  end

  // cell chain
  logic signed [SB-1:0]  cmax [MAX_POOL];
  logic signed [SB-1:0]  cmin [MAX_POOL];
  logic signed [CSW-1:0] csum [MAX_POOL];

  for (genvar x = 0; x < MAX_POOL; x++) begin : g_cell
    if (x == 0) begin : g_head
      wpf_cell #(.SB(SB), .CSW(CSW)) u_cell (
        .clk(clk), .shift_en(shift_en),
        .in_max(nc_max_r), .in_min(nc_min_r), .in_sum(nc_sum_r),
        .out_max(cmax[x]), .out_min(cmin[x]), .out_sum(csum[x])
      );
    end else begin : g_body
      wpf_cell #(.SB(SB), .CSW(CSW)) u_cell (
        .clk(clk), .shift_en(shift_en),
        .in_max(cmax[x-1]), .in_min(cmin[x-1]), .in_sum(csum[x-1]),
        .out_max(cmax[x]), .out_min(cmin[x]), .out_sum(csum[x])
      );
    end
  end

  // window reduction
  logic signed [SB-1:0]  red_max, red_min;
  logic signed [TSW-1:0] red_sum;

  always_comb begin
    red_max = cmax[0];
    red_min = cmin[0];
    red_sum = TSW'(csum[0]);
    for (int x = 1; x < MAX_POOL; x++) begin
      if (PW_W'(x) < pw_c) begin
        if (cmax[x] > red_max) red_max = cmax[x];
        if (cmin[x] < red_min) red_min = cmin[x];
        red_sum = red_sum + TSW'(csum[x]);
      end
    end
  end

  logic [DVW-1:0]       divisor;
  logic signed [SB-1:0] div_q;

  assign divisor = DVW'(pw_c) * DVW'(ph_c);

  wpf_div #(.TSW(TSW), .DVW(DVW), .SB(SB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(red_sum), .divisor(divisor),
    .done(div_done), .quotient(div_q)
  );

  // result staging and output register
  logic signed [SB-1:0]  res_r;
  logic [OUT_POS_W-1:0]  o_row_r, o_col_r;
  logic                  o_done_r;
  logic                  res_ready;
  logic                  out_valid_r;

  assign res_ready = (state_r == ST_RED && !avg_mode) || (state_r == ST_DIV && div_done);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      o_row_r  <= oy_e;
      o_col_r  <= ox_e;
      o_done_r <= last;
    end
    if (state_r == ST_RED && !avg_mode)
      res_r <= (mode_r == MODE_MIN) ? red_min : red_max;
    else if (state_r == ST_DIV && div_done)
      res_r <= div_q;
  end

  assign emit = res_pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready) res_pend_r <= 1'b1;
      else if (emit) res_pend_r <= 1'b0;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pooled_value <= res_r;
      out_row          <= o_row_r;
      out_col          <= o_col_r;
      out_frame_done   <= o_done_r;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE)) else $error("item accepted but control stayed idle");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(wr_slot_r) < CMP_W'(RING))) else $error("line store slot out of range");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(col_r) < CMP_W'(MAX_WIDTH))) else $error("column position out of range");
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_ready |-> !res_pend_r) else $error("result overwrote a pending result");

endmodule

/* rtl/wpf_cell.sv */
module wpf_cell
  import wpf_pkg::*;
#(
  parameter int SB  = SAMPLE_BITS_DEF,
  parameter int CSW = SAMPLE_BITS_DEF + 3
) (
  input  logic                  clk,
  input  logic                  shift_en,
  input  logic signed [SB-1:0]  in_max,
  input  logic signed [SB-1:0]  in_min,
  input  logic signed [CSW-1:0] in_sum,
  output logic signed [SB-1:0]  out_max,
  output logic signed [SB-1:0]  out_min,
  output logic signed [CSW-1:0] out_sum
);

  logic signed [SB-1:0]  max_r;
  logic signed [SB-1:0]  min_r;
  logic signed [CSW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      max_r <= in_max;
      min_r <= in_min;
      sum_r <= in_sum;
    end
  end

  assign out_max = max_r;
  assign out_min = min_r;
  assign out_sum = sum_r;

endmodule

/* rtl/wpf_div.sv */
module wpf_div
  import wpf_pkg::*;
#(
  parameter int TSW = SAMPLE_BITS_DEF + 6,
  parameter int DVW = 7,
  parameter int SB  = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [TSW-1:0] dividend,
  input  logic [DVW-1:0]        divisor,
  output logic                  done,
  output logic signed [SB-1:0]  quotient
);

  localparam int CNT_W = $clog2(TSW + 1);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TSW-1:0]   quo_r;
  logic [DVW-1:0]   rem_r, dvs_r;
  logic [DVW:0]     trial;
  logic             qbit;
  logic [TSW-1:0]   mag;
  logic [TSW-1:0]   signed_q;

  assign mag   = dividend[TSW-1] ? TSW'(-dividend) : TSW'(dividend);
  assign trial = {rem_r, quo_r[TSW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(TSW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[TSW-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[TSW-2:0], qbit};
      rem_r <= qbit ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
    end
  end

  assign signed_q = neg_r ? TSW'(-quo_r) : quo_r;
  assign quotient = signed_q[SB-1:0];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(start && busy_r)) else $error("divider restarted while busy");
      assert (!(done_r && busy_r)) else $error("divider done while busy");
    end
  end
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("divider count ran out while busy");

endmodule

/* test/testbench.sv */
module testbench;
  import wpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               done;
  } pooled_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [31:0] data;
    logic [15:0] smp;
    bit          typed;
    pooled_t     res;
  } step_t;

  localparam int RING = 7;
  localparam int DRAIN = 64;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_sample, out_pooled_value;
  logic [9:0] out_row, out_col;
  logic out_frame_done;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  window_pooling_forward dut (.*);

  // predictor state
  logic [1:0] p_mode;
  logic [3:0] p_pw, p_ph, p_stride;
  logic [10:0] p_iw, p_ih;
  logic [15:0] line_rows [RING*1024];
  int cells [64];
  int col_pos, row_pos;

  pooled_t pooled_expected [$];
  int failures = 0;
  int items_sent = 0;
  longint cycle = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic bit idle_now();
    if ((cycle % 5000) >= 4000) return 0;
    return $urandom_range(0, 99) < 26;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic config_predict(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_MODE:   p_mode = v[1:0];
      REG_PW:     p_pw = v[3:0];
      REG_PH:     p_ph = v[3:0];
      REG_STRIDE: p_stride = v[3:0];
      REG_IW:     p_iw = v[10:0];
      REG_IH:     p_ih = v[10:0];
      default:    return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic pool_predict(logic signed [15:0] s, output bit got, output pooled_t res);
    int pw, ph, st, w, h, c, r, v, slot, best, lr, lc;
    longint sum;
    pw = clamp(p_pw, 8);
    ph = clamp(p_ph, 8);
    st = (p_stride == 0) ? 1 : p_stride;
    w = clamp(p_iw, 1024);
    h = clamp(p_ih, 1024);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    got = 0;
    for (int x = 7; x > 0; x--)
      for (int y = 0; y < 8; y++) cells[x*8+y] = cells[(x-1)*8+y];
    for (int y = 0; y < 8; y++) begin
      v = 0;
      if (y == 0) v = s;
      else if (y < ph) begin
        slot = ((r % RING) + RING - (y % RING)) % RING;
        v = $signed(line_rows[slot*1024+c]);
      end
      cells[y] = v;
    end
    line_rows[(r % RING)*1024+c] = s;
    if (pw <= w && ph <= h && r + 1 >= ph && c + 1 >= pw &&
        ((r + 1 - ph) % st) == 0 && ((c + 1 - pw) % st) == 0) begin
      lr = ((h - ph) / st) * st + ph - 1;
      lc = ((w - pw) / st) * st + pw - 1;
      best = cells[0];
      sum = 0;
      for (int x = 0; x < pw; x++)
        for (int y = 0; y < ph; y++) begin
          v = cells[x*8+y];
          sum += v;
          if (p_mode == MODE_MAX && v > best) best = v;
          if (p_mode == MODE_MIN && v < best) best = v;
        end
      if (p_mode == MODE_AVERAGE || p_mode == MODE_AVG_ALT) best = int'(sum / (pw * ph));
      res.value = best[15:0];
      res.row = 10'((r + 1 - ph) / st);
      res.col = 10'((c + 1 - pw) / st);
      res.done = (r == lr && c == lc);
      got = 1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic send_sample(logic [15:0] s, bit typed, pooled_t typed_res);
    bit got;
    pooled_t res;
    @(negedge clk);
    while (idle_now()) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_sample = s;
    do @(posedge clk); while (!in_ready);
    pool_predict(s, got, res);
    if (typed) pooled_expected.push_back(typed_res);
    else if (got) pooled_expected.push_back(res);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pooled_expected.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0;
    penable = 0;
    config_predict(idx, v);
  endtask

  always @(negedge clk) out_ready <= !idle_now();

  always @(posedge clk) begin
    pooled_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pooled_expected.size() == 0) begin
        $error("unexpected item: value %h row %0d col %0d", out_pooled_value, out_row, out_col);
        failures++;
      end else begin
        e = pooled_expected.pop_front();
        if (out_pooled_value !== e.value) begin
          $error("pooled_value: expected %h, got %h", e.value, out_pooled_value);
          failures++;
        end
        if (out_row !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, out_row);
          failures++;
        end
        if (out_col !== e.col) begin
          $error("out_col: expected %0d, got %0d", e.col, out_col);
          failures++;
        end
        if (out_frame_done !== e.done) begin
          $error("frame_done: expected %0d, got %0d", e.done, out_frame_done);
          failures++;
        end
      end
    end
  end

  step_t directed [] = '{
    '{0, REG_MODE,   32'd0,    16'h1234, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_PW,     32'd1,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_PH,     32'd1,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_STRIDE, 32'd1,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_IW,     32'd1,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_IH,     32'd1,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h7fff, 1, '{16'h7fff, 10'd0, 10'd0, 1'b1}},
    '{0, REG_MODE,   32'd0,    16'h8000, 1, '{16'h8000, 10'd0, 10'd0, 1'b1}},
    '{0, REG_MODE,   32'd0,    16'hffff, 1, '{16'hffff, 10'd0, 10'd0, 1'b1}},
    '{1, REG_MODE,   MODE_MIN, 16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h8000, 1, '{16'h8000, 10'd0, 10'd0, 1'b1}},
    '{1, REG_MODE,   MODE_AVG_ALT, 16'h0, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0005, 1, '{16'h0005, 10'd0, 10'd0, 1'b1}},
    '{1, REG_IW,     32'd2,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_IH,     32'd2,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_PW,     32'd2,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_PH,     32'd2,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_STRIDE, 32'd0,    16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_MODE,   MODE_MAX, 16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h7fff, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h8000, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0001, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0002, 1, '{16'h7fff, 10'd0, 10'd0, 1'b1}},
    '{1, REG_MODE,   MODE_AVERAGE, 16'h0, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'hffff, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0000, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0000, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0000, 1, '{16'h0000, 10'd0, 10'd0, 1'b1}},
    '{1, REG_NONE6,  32'hffff, 16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{1, REG_PW,     32'd15,   16'h0,    0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h4321, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'hbcde, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'h0f0f, 0, '{16'h0, 10'd0, 10'd0, 1'b0}},
    '{0, REG_MODE,   32'd0,    16'hf0f0, 0, '{16'h0, 10'd0, 10'd0, 1'b0}}
  };

  function automatic int pick_pool();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 0;
    if (k == 1) return 15;
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_dim();
    int k;
    k = $urandom_range(0, 29);
    if (k == 0) return 0;
    if (k == 1) return 1024;
    if (k == 2) return 2047;
    return $urandom_range(1, 14);
  endfunction

  initial begin
    int iw, ih, n, k;
    rst_n = 0;
    in_valid = 0;
    in_sample = 0;
    out_ready = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    p_mode = MODE_MAX;
    p_pw = 2;
    p_ph = 2;
    p_stride = 2;
    p_iw = 1024;
    p_ih = 1024;
    col_pos = 0;
    row_pos = 0;
    foreach (line_rows[i]) line_rows[i] = 0;
    foreach (cells[i]) cells[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        reg_write(directed[i].idx, directed[i].data);
      end else
        send_sample(directed[i].smp, directed[i].typed, directed[i].res);
    end

    while (items_sent < 1340) begin
      drain();
      iw = pick_dim();
      ih = pick_dim();
      reg_write(REG_MODE, $urandom_range(0, 3));
      reg_write(REG_PW, pick_pool());
      reg_write(REG_PH, pick_pool());
      reg_write(REG_STRIDE, $urandom_range(0, 15) > 12 ? $urandom_range(9, 15)
                                                       : $urandom_range(0, 8));
      reg_write(REG_IW, iw);
      reg_write(REG_IH, ih);
      if ($urandom_range(0, 7) == 0) reg_write($urandom_range(0, 1) ? REG_NONE6 : REG_NONE7,
                                               $urandom);
      if (iw > 14 || ih > 14) n = $urandom_range(20, 200);
      else begin
        n = clamp(iw, 1024) * clamp(ih, 1024) * $urandom_range(1, 2);
        k = $urandom_range(0, 9);
        if (k == 0) n = $urandom_range(1, n);
      end
      repeat (n) send_sample($urandom_range(0, 65535), 0, '{16'h0, 10'd0, 10'd0, 1'b0});
    end

    drain();
    if (failures == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
